// ----- rtl/pdm_pkg.sv -----
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared types, codes and constants for the position PID motor drive.
// ----------------------------------------------------------------------------
package pdm_pkg;

    // Field and datapath widths
    localparam int POS_W      = 16;
    localparam int DT_W       = 24;
    localparam int E_W        = 17;
    localparam int DIFF_W     = 18;
    localparam int DMAG_W     = 17;
    localparam int DE_NUM_W   = 37;
    localparam int EDT_W      = 40;
    localparam int INT_W      = 64;
    localparam int URATE_W    = 20;
    localparam int MAG_W      = 44;
    localparam int GAIN_W     = 32;
    localparam int ACC_W      = 62;
    localparam int FRAC_W     = 24;
    localparam int DRV_W      = INT_W - FRAC_W;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 6;
    localparam int DIV_STEPS  = INT_W;
    localparam int MUL_STEPS  = GAIN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Gain lanes
    localparam int N_LANES = 3;
    localparam int LANE_P  = 0;
    localparam int LANE_D  = 1;
    localparam int LANE_I  = 2;

    // Arithmetic constants
    localparam logic [URATE_W-1:0] USEC_PER_S = URATE_W'(1000000);
    localparam logic [ACC_W-1:0]   TERM_LIMIT = ACC_W'(1) << 60;
    localparam logic [INT_W-1:0]   INT_MAX    = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic [INT_W-1:0]   INT_MIN    = {1'b1, {(INT_W-1){1'b0}}};
    localparam logic [BYTE_W-1:0]  RAISE_TOP  = BYTE_W'(54);

    // Settle counter constants
    localparam logic [BYTE_W-1:0] SETTLE_DROP   = BYTE_W'(5);
    localparam logic [BYTE_W-1:0] SETTLE_RELOAD = BYTE_W'(20);
    localparam logic [BYTE_W-1:0] SETTLE_MAX    = BYTE_W'(255);

    // Register reset values
    localparam logic [POS_W-1:0]  TARGET_RST = POS_W'(2023);
    localparam logic [GAIN_W-1:0] PROP_RST   = GAIN_W'(16777216);
    localparam logic [GAIN_W-1:0] INTEG_RST  = GAIN_W'(336);
    localparam logic [GAIN_W-1:0] DERIV_RST  = GAIN_W'(838861);
    localparam logic [BYTE_W-1:0] BAND_RST   = BYTE_W'(5);
    localparam logic [BYTE_W-1:0] MIN_RST    = BYTE_W'(55);
    localparam logic [BYTE_W-1:0] THR_RST    = BYTE_W'(2);
    localparam logic [BYTE_W-1:0] MAX_RST    = BYTE_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET    = 3'd0,
        CFG_PROP_GAIN = 3'd1,
        CFG_INTEG_GAIN = 3'd2,
        CFG_DERIV_GAIN = 3'd3,
        CFG_SETTLE    = 3'd4,
        CFG_MIN_DRIVE = 3'd5,
        CFG_MIN_THR   = 3'd6,
        CFG_MAX_DRIVE = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIR_FWD  = 2'd0,
        DIR_REV  = 2'd1,
        DIR_STOP = 2'd2
    } dir_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_PROD,
        ST_INTEG,
        ST_DIV,
        ST_MUL,
        ST_SUM1,
        ST_SUM2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [DT_W-1:0]         elapsed_us;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] pwm_duty;
        logic [1:0]        direction;
        logic              run_done;
    } out_item_t;

endpackage

// ----- rtl/pid_position_motor_drive.sv -----
// ----------------------------------------------------------------------------
// pid_position_motor_drive
// Position PID controller with saturating integral, PWM cap and deadband raise.
// ----------------------------------------------------------------------------
// One input beat is one control tick: encoder position and microseconds since
// the last tick. The block returns one result beat per tick with duty,
// direction and a run-done flag. It works on one tick at a time and is ready
// for the next one only once the result of the last is loaded into the output
// register. Two bit-serial restoring dividers run side by side (the
// derivative by elapsed time, and the 64-bit integral by one million),
// followed by three shift-add gain multipliers that run side by side, one
// gain bit per cycle. A finished result waits in the output register, so the
// block takes the next tick while it is unread; it only stalls in its last
// step if a second result is ready before the first is taken. Configuration
// writes land at once and should only be issued while no tick is in flight.
module pid_position_motor_drive
    import pdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  target_reg;
    logic [GAIN_W-1:0] gain_reg [N_LANES];
    logic [BYTE_W-1:0] band_reg;
    logic [BYTE_W-1:0] min_drive_reg;
    logic [BYTE_W-1:0] thr_reg;
    logic [BYTE_W-1:0] max_drive_reg;

    // ------------------------------------------------------------------
    // Control and loop state
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [E_W-1:0]    prev_reg;
    logic [INT_W-1:0]  integ_reg;
    logic [BYTE_W-1:0] settle_reg;
    logic              out_valid_reg;

    // ------------------------------------------------------------------
    // Per-tick working registers (no reset needed)
    // ------------------------------------------------------------------
    logic [E_W-1:0]      e_reg;
    logic [DT_W-1:0]     dt_reg;
    logic [DIFF_W-1:0]   diff_reg;
    logic [EDT_W-1:0]    edt_mag_reg;
    logic                de_neg_reg;
    logic                int_neg_reg;
    logic [DE_NUM_W-1:0] deq_reg;
    logic [DT_W-1:0]     derem_reg;
    logic [INT_W-1:0]    iq_reg;
    logic [URATE_W-1:0]  irem_reg;
    logic [GAIN_W-1:0]   gsh_reg [N_LANES];
    logic [ACC_W-1:0]    acc_reg [N_LANES];
    logic                sat_reg [N_LANES];
    logic [INT_W-1:0]    sum_reg;
    out_item_t           out_reg;

    // Handshake decode
    logic in_take;
    logic out_load;

    // ------------------------------------------------------------------
    // Error, derivative numerator and integral update
    // ------------------------------------------------------------------
    logic [E_W-1:0]      e_next;
    logic [E_W-1:0]      e_mag;
    logic [DIFF_W-1:0]   diff_next;
    logic [DIFF_W-1:0]   diff_mag;
    logic [DE_NUM_W-1:0] de_num;
    logic [EDT_W-1:0]    edt_mag_next;
    logic [INT_W-1:0]    edt_signed;
    logic [INT_W:0]      int_sum;
    logic [INT_W-1:0]    integ_next;
    logic [INT_W-1:0]    integ_mag;

    assign e_next = {in_data.position[POS_W-1], in_data.position}
                  - {target_reg[POS_W-1], target_reg};
    assign e_mag  = e_reg[E_W-1] ? (E_W'(0) - e_reg) : e_reg;

    assign diff_next = {e_reg[E_W-1], e_reg} - {prev_reg[E_W-1], prev_reg};
    assign diff_mag  = diff_reg[DIFF_W-1] ? (DIFF_W'(0) - diff_reg) : diff_reg;
    assign de_num    = DE_NUM_W'(diff_mag[DMAG_W-1:0]) * DE_NUM_W'(USEC_PER_S);

    assign edt_mag_next = EDT_W'(e_mag[POS_W-1:0]) * EDT_W'(dt_reg);
    assign edt_signed   = e_reg[E_W-1] ? (INT_W'(0) - INT_W'(edt_mag_reg))
                                       : INT_W'(edt_mag_reg);
    assign int_sum      = {integ_reg[INT_W-1], integ_reg}
                        + {edt_signed[INT_W-1], edt_signed};

    // Clamp the running integral at the signed 64-bit limits
    always_comb
    begin
        if (int_sum[INT_W] != int_sum[INT_W-1])
        begin
            integ_next = int_sum[INT_W] ? INT_MIN : INT_MAX;
        end
        else
        begin
            integ_next = int_sum[INT_W-1:0];
        end
    end

    assign integ_mag = integ_reg[INT_W-1] ? (INT_W'(0) - integ_reg) : integ_reg;

    // ------------------------------------------------------------------
    // Bit-serial restoring dividers
    // ------------------------------------------------------------------
    logic [DT_W-1:0]     dt_div;
    logic [DT_W:0]       de_shift;
    logic [DT_W:0]       de_sub;
    logic                de_ge;
    logic [DT_W-1:0]     derem_next;
    logic [DE_NUM_W-1:0] deq_next;
    logic [URATE_W:0]    in_shift;
    logic [URATE_W:0]    in_sub;
    logic                in_ge;
    logic [URATE_W-1:0]  irem_next;
    logic [INT_W-1:0]    iq_next;

    // Treat a zero interval as one microsecond
    assign dt_div = (dt_reg == '0) ? DT_W'(1) : dt_reg;

    assign de_shift   = {derem_reg, deq_reg[DE_NUM_W-1]};
    assign de_sub     = de_shift - {1'b0, dt_div};
    assign de_ge      = de_shift >= {1'b0, dt_div};
    assign derem_next = de_ge ? de_sub[DT_W-1:0] : de_shift[DT_W-1:0];
    assign deq_next   = {deq_reg[DE_NUM_W-2:0], de_ge};

    assign in_shift  = {irem_reg, iq_reg[INT_W-1]};
    assign in_sub    = in_shift - {1'b0, USEC_PER_S};
    assign in_ge     = in_shift >= {1'b0, USEC_PER_S};
    assign irem_next = in_ge ? in_sub[URATE_W-1:0] : in_shift[URATE_W-1:0];
    assign iq_next   = {iq_reg[INT_W-2:0], in_ge};

    // ------------------------------------------------------------------
    // Shift-add gain multipliers, one gain bit per cycle, MSB first.
    // The accumulator only grows, so once past the term limit it stays
    // saturated: hold it there with a sticky flag.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] mul_op   [N_LANES];
    logic             lane_neg [N_LANES];
    logic [ACC_W-1:0] acc_sum  [N_LANES];
    logic             acc_over [N_LANES];
    logic [INT_W-1:0] term_mag [N_LANES];
    logic [INT_W-1:0] sterm    [N_LANES];

    assign mul_op[LANE_P]   = MAG_W'(e_mag[POS_W-1:0]);
    assign mul_op[LANE_D]   = MAG_W'(deq_reg);
    assign mul_op[LANE_I]   = iq_reg[MAG_W-1:0];
    assign lane_neg[LANE_P] = e_reg[E_W-1];
    assign lane_neg[LANE_D] = de_neg_reg;
    assign lane_neg[LANE_I] = int_neg_reg;

    always_comb
    begin
        for (int i = 0; i < N_LANES; i++)
        begin
            acc_sum[i]  = {acc_reg[i][ACC_W-2:0], 1'b0}
                        + (gsh_reg[i][GAIN_W-1] ? ACC_W'(mul_op[i]) : ACC_W'(0));
            acc_over[i] = acc_sum[i] > TERM_LIMIT;
            term_mag[i] = sat_reg[i] ? INT_W'(TERM_LIMIT) : INT_W'(acc_reg[i]);
            sterm[i]    = lane_neg[i] ? (INT_W'(0) - term_mag[i]) : term_mag[i];
        end
    end

    // ------------------------------------------------------------------
    // Duty, direction and settle counter from the summed drive
    // ------------------------------------------------------------------
    logic              u_neg;
    logic [INT_W-1:0]  u_mag;
    logic [DRV_W-1:0]  drv;
    logic              drv_small;
    logic              drv_over;
    logic              drv_raise;
    logic [BYTE_W-1:0] duty;
    logic              settled;
    logic [BYTE_W-1:0] settle_step;
    logic              run_done;
    logic [BYTE_W-1:0] settle_next;
    logic [1:0]        dir;

    assign u_neg     = sum_reg[INT_W-1];
    assign u_mag     = u_neg ? (INT_W'(0) - sum_reg) : sum_reg;
    assign drv       = u_mag[INT_W-1:FRAC_W];
    assign drv_small = drv[DRV_W-1:BYTE_W] == '0;
    assign drv_over  = !drv_small || (drv[BYTE_W-1:0] > max_drive_reg);
    assign drv_raise = drv_small && (drv[BYTE_W-1:0] >= thr_reg)
                    && (drv[BYTE_W-1:0] <= RAISE_TOP);

    always_comb
    begin
        if (drv_over)
        begin
            duty = max_drive_reg;
        end
        else if (drv_raise)
        begin
            duty = min_drive_reg;
        end
        else
        begin
            duty = drv[BYTE_W-1:0];
        end
    end

    assign settled = e_mag <= E_W'(band_reg);

    always_comb
    begin
        if (settled)
        begin
            settle_step = (settle_reg >= SETTLE_DROP) ? (settle_reg - SETTLE_DROP)
                                                      : BYTE_W'(0);
        end
        else if (settle_reg != SETTLE_MAX)
        begin
            settle_step = settle_reg + BYTE_W'(1);
        end
        else
        begin
            settle_step = settle_reg;
        end
    end

    assign run_done    = settle_step < SETTLE_DROP;
    assign settle_next = run_done ? SETTLE_RELOAD : settle_step;
    assign dir         = settled ? DIR_STOP : (u_neg ? DIR_REV : DIR_FWD);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:  state_next = ST_PROD;
            ST_PROD:  state_next = ST_INTEG;
            ST_INTEG: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_SUM1;
                end
            end
            ST_SUM1:  state_next = ST_SUM2;
            ST_SUM2:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_DONE: out_load = !out_valid_reg || out_ready;
            default:
            begin
                in_ready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg       <= TARGET_RST;
            gain_reg[LANE_P] <= PROP_RST;
            gain_reg[LANE_I] <= INTEG_RST;
            gain_reg[LANE_D] <= DERIV_RST;
            band_reg         <= BAND_RST;
            min_drive_reg    <= MIN_RST;
            thr_reg          <= THR_RST;
            max_drive_reg    <= MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET:     target_reg       <= cfg_data[POS_W-1:0];
                CFG_PROP_GAIN:  gain_reg[LANE_P] <= cfg_data;
                CFG_INTEG_GAIN: gain_reg[LANE_I] <= cfg_data;
                CFG_DERIV_GAIN: gain_reg[LANE_D] <= cfg_data;
                CFG_SETTLE:     band_reg         <= cfg_data[BYTE_W-1:0];
                CFG_MIN_DRIVE:  min_drive_reg    <= cfg_data[BYTE_W-1:0];
                CFG_MIN_THR:    thr_reg          <= cfg_data[BYTE_W-1:0];
                CFG_MAX_DRIVE:  max_drive_reg    <= cfg_data[BYTE_W-1:0];
                default:        target_reg       <= target_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state, loop memory and output valid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            prev_reg      <= '0;
            integ_reg     <= '0;
            settle_reg    <= SETTLE_RELOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Step counter: clear ahead of the divide, advance through
            // the divide and the multiply.
            if (state_reg == ST_INTEG)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV || state_reg == ST_MUL)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (state_reg == ST_DIFF)
            begin
                prev_reg <= e_reg;
            end

            if (state_reg == ST_PROD)
            begin
                integ_reg <= integ_next;
            end

            if (out_load)
            begin
                settle_reg    <= settle_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            e_reg  <= e_next;
            dt_reg <= in_data.elapsed_us;
        end

        if (state_reg == ST_DIFF)
        begin
            diff_reg    <= diff_next;
            edt_mag_reg <= edt_mag_next;
        end

        // Load the derivative divider: |diff| * 1e6 over the interval
        if (state_reg == ST_PROD)
        begin
            deq_reg    <= de_num;
            derem_reg  <= '0;
            de_neg_reg <= diff_reg[DIFF_W-1];
        end

        // Load the integral divider and the gain shifters
        if (state_reg == ST_INTEG)
        begin
            iq_reg      <= integ_mag;
            irem_reg    <= '0;
            int_neg_reg <= integ_reg[INT_W-1];
            for (int i = 0; i < N_LANES; i++)
            begin
                gsh_reg[i] <= gain_reg[i];
                acc_reg[i] <= '0;
                sat_reg[i] <= 1'b0;
            end
        end

        if (state_reg == ST_DIV)
        begin
            iq_reg   <= iq_next;
            irem_reg <= irem_next;
            if (cnt_reg < CNT_W'(DE_NUM_W))
            begin
                deq_reg   <= deq_next;
                derem_reg <= derem_next;
            end
        end

        if (state_reg == ST_MUL)
        begin
            for (int i = 0; i < N_LANES; i++)
            begin
                gsh_reg[i] <= {gsh_reg[i][GAIN_W-2:0], 1'b0};
                if (!sat_reg[i])
                begin
                    acc_reg[i] <= acc_sum[i];
                    sat_reg[i] <= acc_over[i];
                end
            end
        end

        if (state_reg == ST_SUM1)
        begin
            sum_reg <= sterm[LANE_P] + sterm[LANE_D];
        end

        if (state_reg == ST_SUM2)
        begin
            sum_reg <= sum_reg + sterm[LANE_I];
        end

        if (out_load)
        begin
            out_reg.pwm_duty  <= duty;
            out_reg.direction <= dir;
            out_reg.run_done  <= run_done;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A tick just taken keeps the input closed while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a tick was taken");

    // A result beat only appears out of the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
    else $error("result valid rose outside the final step");

    // The settle counter reloads before it can sit below the drop size
    assert property (@(posedge clk) disable iff (!rst_n)
        settle_reg >= SETTLE_DROP)
    else $error("settle counter left below the drop size");

    // The derivative remainder stays below its divisor after the divide
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> derem_reg < dt_div)
    else $error("derivative divider remainder out of range");

    // An unsaturated gain product never exceeds the term limit
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM1 |->
            (sat_reg[LANE_P] || acc_reg[LANE_P] <= TERM_LIMIT)
         && (sat_reg[LANE_D] || acc_reg[LANE_D] <= TERM_LIMIT)
         && (sat_reg[LANE_I] || acc_reg[LANE_I] <= TERM_LIMIT))
    else $error("gain product passed the term limit without saturating");

endmodule
